// ===== rtl/waveform_window_statistics_top_assert.svh =====
// Assertion macros used by the window statistics checker.
`ifndef WAVEFORM_WINDOW_STATISTICS_TOP_ASSERT_SVH
`define WAVEFORM_WINDOW_STATISTICS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define WWS_ASSERT_IMPL(LBL, ANT, CON) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANT) |-> (CON)) \
    else $error("%m: window statistics check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define WWS_ASSERT_NEXT(LBL, ANT, CON) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANT) |=> (CON)) \
    else $error("%m: window statistics check failed");

`endif

// ===== rtl/wws_pkg.sv =====
// Shared types and constants for the window statistics block.
package wws_pkg;

  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_MAX_COUNT    = 4096;

  localparam int DATA_W  = 16;
  localparam int COUNT_W = 13;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mean;
    logic        [DATA_W-1:0] rms;
    logic signed [DATA_W-1:0] minimum;
    logic signed [DATA_W-1:0] maximum;
    logic        [DATA_W-1:0] peak_to_peak;
    logic        [COUNT_W-1:0] sample_count;
    logic                     overflow;
  } out_t;

endpackage

// ===== rtl/waveform_window_statistics_top.sv =====
// Window statistics: mean, RMS, minimum, maximum and peak-to-peak of a sample window.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in_     | input     | in_valid / in_ready  | sample, last
//  out_    | output    | out_valid/ out_ready | mean, rms, minimum, maximum, peak_to_peak,
//          |           |                      | sample_count, overflow
//
// A sample's square is added to the sum of squares one multiplier bit per cycle.
// A last sample adds 2 * (2 * SAMPLE_WIDTH - 1 + clog2(MAX_COUNT + 1)) restoring divide
// steps and SAMPLE_WIDTH square root steps, then loads the result register.
// Reset clears the window; there is no clearing pass.
// A finished result waits in the output register; the next window is accepted meanwhile,
// and only its own end stalls until the previous result has been taken.
module waveform_window_statistics_top #(
  parameter int SAMPLE_WIDTH = wws_pkg::DEF_SAMPLE_WIDTH,
  parameter int MAX_COUNT    = wws_pkg::DEF_MAX_COUNT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  wws_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wws_pkg::out_t out_data
);
  import wws_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = $clog2(MAX_COUNT + 1);
  localparam int SUMW = SW + CW;
  localparam int QW   = 2 * SW - 1 + CW;
  localparam int MW   = 2 * SW - 1;
  localparam int RTW  = SW + 3;
  localparam int CNTW = $clog2(QW);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SQR      = 3'd1;
  localparam logic [2:0] ST_DIV_MEAN = 3'd2;
  localparam logic [2:0] ST_DIV_SQ   = 3'd3;
  localparam logic [2:0] ST_SQRT     = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_data_r, out_data_nxt;
  logic signed [SUMW-1:0] sum_r, sum_nxt;
  logic [QW-1:0]          sq_r, sq_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   dropped_r, dropped_nxt;
  logic signed [SW-1:0]   min_r, min_nxt;
  logic signed [SW-1:0]   max_r, max_nxt;
  logic                   last_r, last_nxt;
  logic [SW-1:0]          mult_r, mult_nxt;
  logic [MW-1:0]          mcand_r, mcand_nxt;
  logic [QW-1:0]          div_d_r, div_d_nxt;
  logic [CW-1:0]          div_rem_r, div_rem_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic [SW-1:0]          qmag_r, qmag_nxt;
  logic [SW:0]            srem_r, srem_nxt;
  logic [SW-1:0]          root_r, root_nxt;

  logic signed [SW-1:0]   smp;
  logic [SW-1:0]          mag;
  logic                   room;
  logic [SUMW-1:0]        sum_mag;
  logic [CW:0]            div_cat;
  logic                   div_ge;
  logic [CW-1:0]          div_rem_step;
  logic [QW-1:0]          div_d_step;
  logic [RTW-1:0]         sq_remsh;
  logic [RTW-1:0]         sq_trial;
  logic                   sq_ge;
  logic signed [SW:0]     mean_full;
  logic signed [SW:0]     p2p_full;

  generate
    if (SW <= DATA_W) begin : g_narrow
      assign smp = in_data.sample[SW-1:0];
    end else begin : g_wide
      assign smp = {{(SW - DATA_W){1'b0}}, in_data.sample};
    end
  endgenerate

  assign mag     = smp[SW-1] ? SW'(-smp) : SW'(smp);
  assign room    = (count_r < CW'(MAX_COUNT));
  assign sum_mag = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);

  // Restoring divide by the sample count, one quotient bit per cycle.
  assign div_cat      = {div_rem_r, div_d_r[QW-1]};
  assign div_ge       = (div_cat >= {1'b0, count_r});
  assign div_rem_step = div_ge ? CW'(div_cat - {1'b0, count_r}) : div_cat[CW-1:0];
  assign div_d_step   = {div_d_r[QW-2:0], div_ge};

  // Restoring square root, two radicand bits per cycle.
  assign sq_remsh = {srem_r, div_d_r[2*SW-1 -: 2]};
  assign sq_trial = RTW'({root_r, 2'b01});
  assign sq_ge    = (sq_remsh >= sq_trial);

  assign mean_full = sum_r[SUMW-1] ? -$signed({1'b0, qmag_r}) : $signed({1'b0, qmag_r});
  assign p2p_full  = (SW + 1)'(max_r) - (SW + 1)'(min_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    last_nxt      = last_r;
    mult_nxt      = mult_r;
    mcand_nxt     = mcand_r;
    div_d_nxt     = div_d_r;
    div_rem_nxt   = div_rem_r;
    cnt_nxt       = cnt_r;
    qmag_nxt      = qmag_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt = in_data.last;
          if (room) begin
            if (count_r == '0) begin
              min_nxt = smp;
              max_nxt = smp;
            end else begin
              if (smp < min_r) min_nxt = smp;
              if (smp > max_r) max_nxt = smp;
            end
            sum_nxt   = sum_r + SUMW'(smp);
            count_nxt = count_r + CW'(1);
            mult_nxt  = mag;
          end else begin
            // window full: drop the sample, keep the flag
            dropped_nxt = 1'b1;
            mult_nxt    = '0;
          end
          mcand_nxt = MW'(mag);
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mult_r[0]) begin
          sq_nxt = sq_r + QW'(mcand_r);
        end
        mcand_nxt = mcand_r << 1;
        mult_nxt  = mult_r >> 1;
        if ((mult_r >> 1) == '0) begin
          if (last_r) begin
            div_d_nxt   = QW'(sum_mag);
            div_rem_nxt = '0;
            cnt_nxt     = CNTW'(QW - 1);
            state_nxt   = ST_DIV_MEAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV_MEAN: begin
        div_d_nxt   = div_d_step;
        div_rem_nxt = div_rem_step;
        cnt_nxt     = cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          qmag_nxt    = SW'(div_d_step);
          div_d_nxt   = sq_r;
          div_rem_nxt = '0;
          cnt_nxt     = CNTW'(QW - 1);
          state_nxt   = ST_DIV_SQ;
        end
      end
      ST_DIV_SQ: begin
        div_d_nxt   = div_d_step;
        div_rem_nxt = div_rem_step;
        cnt_nxt     = cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          srem_nxt  = '0;
          root_nxt  = '0;
          cnt_nxt   = CNTW'(SW - 1);
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        srem_nxt  = sq_ge ? (SW + 1)'(sq_remsh - sq_trial) : (SW + 1)'(sq_remsh);
        root_nxt  = {root_r[SW-2:0], sq_ge};
        div_d_nxt = div_d_r << 2;
        cnt_nxt   = cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the previous result has been taken
        if (!out_valid_r || out_ready) begin
          out_data_nxt.mean         = DATA_W'(mean_full);
          out_data_nxt.rms          = DATA_W'(root_r);
          out_data_nxt.minimum      = DATA_W'(min_r);
          out_data_nxt.maximum      = DATA_W'(max_r);
          out_data_nxt.peak_to_peak = DATA_W'(p2p_full);
          out_data_nxt.sample_count = COUNT_W'(count_r);
          out_data_nxt.overflow     = dropped_r;
          out_valid_nxt             = 1'b1;
          sum_nxt                   = '0;
          sq_nxt                    = '0;
          count_nxt                 = '0;
          dropped_nxt               = 1'b0;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      sq_r        <= '0;
      count_r     <= '0;
      dropped_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    min_r      <= min_nxt;
    max_r      <= max_nxt;
    last_r     <= last_nxt;
    mult_r     <= mult_nxt;
    mcand_r    <= mcand_nxt;
    div_d_r    <= div_d_nxt;
    div_rem_r  <= div_rem_nxt;
    cnt_r      <= cnt_nxt;
    qmag_r     <= qmag_nxt;
    srem_r     <= srem_nxt;
    root_r     <= root_nxt;
  end

endmodule

// ===== rtl/wws_checker.sv =====
// Port-level checker for the window statistics block, bound to its top level.
`include "waveform_window_statistics_top_assert.svh"

module wws_checker #(
  parameter int SAMPLE_WIDTH = wws_pkg::DEF_SAMPLE_WIDTH
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input wws_pkg::out_t out_data
);
  import wws_pkg::*;

  `WWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `WWS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
  `WWS_ASSERT_IMPL(a_p2p, out_valid, out_data.peak_to_peak == DATA_W'(out_data.maximum - out_data.minimum))
  // the truncated mean always lies between the extremes
  `WWS_ASSERT_IMPL(a_mean_range, out_valid && (SAMPLE_WIDTH <= DATA_W), (out_data.mean >= out_data.minimum) && (out_data.mean <= out_data.maximum))
  // a result is only produced at a window end, while input is held off
  `WWS_ASSERT_IMPL(a_result_after_stall, $rose(out_valid), !$past(in_ready))

endmodule

bind waveform_window_statistics_top wws_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_wws_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== tb/tb_waveform_window_statistics_top.sv =====
// Self-checking testbench for the window statistics block (mean, RMS, min, max, peak-to-peak).
`timescale 1ns / 100ps

module tb_waveform_window_statistics_top;
  import wws_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int LONG_HOLD  = 600;
  localparam int DRAIN_WAIT = 200;
  localparam int RANDOM_ITEMS = 900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // window accumulator of the predictor
  longint          acc_sum;
  longint unsigned acc_sq;
  longint          acc_min;
  longint          acc_max;
  longint unsigned acc_count;
  bit              acc_dropped;

  out_t expected_stats[$];

  int mismatches       = 0;
  int results_checked  = 0;
  int windows_sent     = 0;
  int samples_sent     = 0;
  int samples_dropped  = 0;

  bit gaps_on       = 1'b1;
  bit ready_gaps_on = 1'b1;
  int hold_req_id   = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int stall_left    = 0;

  waveform_window_statistics_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(30_000_000);
    $display("timeout with %0d results still outstanding", expected_stats.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic int random_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      v = int'($signed(16'($urandom)));
    end else if (r < 50) begin
      v = $urandom_range(0, 30);
      v -= 15;
    end else if (r < 65) begin
      case ($urandom_range(0, 4))
        0: v = -32768;
        1: v = 32767;
        2: v = -1;
        3: v = 0;
        default: v = 1;
      endcase
    end else begin
      v = $urandom_range(0, 2046);
      v -= 1023;
    end
    return v;
  endfunction

  function automatic void clear_window();
    acc_sum     = 0;
    acc_sq      = 0;
    acc_min     = 0;
    acc_max     = 0;
    acc_count   = 0;
    acc_dropped = 1'b0;
  endfunction

  // Fold one accepted sample into the window; queue the statistics on a last mark.
  function automatic void fold_sample(in_t it);
    longint s;
    longint mean;
    out_t   stats;
    s = longint'(it.sample);
    samples_sent++;
    if (acc_count < DEF_MAX_COUNT) begin
      if (acc_count == 0) begin
        acc_min = s;
        acc_max = s;
      end else begin
        if (s < acc_min) acc_min = s;
        if (s > acc_max) acc_max = s;
      end
      acc_sum += s;
      acc_sq  += longint'(s * s);
      acc_count++;
    end else begin
      acc_dropped = 1'b1;
      samples_dropped++;
    end
    if (it.last) begin
      mean = acc_sum / longint'(acc_count);
      stats.mean         = 16'(mean);
      stats.rms          = 16'(floor_sqrt(acc_sq / acc_count));
      stats.minimum      = 16'(acc_min);
      stats.maximum      = 16'(acc_max);
      stats.peak_to_peak = 16'(acc_max - acc_min);
      stats.sample_count = 13'(acc_count);
      stats.overflow     = acc_dropped;
      expected_stats.insert(expected_stats.size(), stats);
      windows_sent++;
      clear_window();
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    mismatches++;
    $display("[%0t] MISMATCH result %0d %s: got %0d expected %0d",
             $realtime, results_checked, what, got, exp);
  endtask

  task automatic send_sample(input int s, input bit l);
    in_t it;
    int  gap;
    it.sample = 16'(s);
    it.last   = l;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    fold_sample(it);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req_id != hold_seen) begin
        hold_seen = hold_req_id;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (ready_gaps_on && $urandom_range(0, 99) < 15) begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    out_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (expected_stats.size() == 0) begin
        report_mismatch("unexpected result, mean", longint'(out_data.mean), 0);
      end else begin
        exp = expected_stats.pop_front();
        if (out_data.mean !== exp.mean)
          report_mismatch("mean", longint'(out_data.mean), longint'(exp.mean));
        if (out_data.rms !== exp.rms)
          report_mismatch("rms", longint'(out_data.rms), longint'(exp.rms));
        if (out_data.minimum !== exp.minimum)
          report_mismatch("minimum", longint'(out_data.minimum), longint'(exp.minimum));
        if (out_data.maximum !== exp.maximum)
          report_mismatch("maximum", longint'(out_data.maximum), longint'(exp.maximum));
        if (out_data.peak_to_peak !== exp.peak_to_peak)
          report_mismatch("peak_to_peak", longint'(out_data.peak_to_peak),
                          longint'(exp.peak_to_peak));
        if (out_data.sample_count !== exp.sample_count)
          report_mismatch("sample_count", longint'(out_data.sample_count),
                          longint'(exp.sample_count));
        if (out_data.overflow !== exp.overflow)
          report_mismatch("overflow", longint'(out_data.overflow), longint'(exp.overflow));
      end
      results_checked++;
    end
  end

  // Extreme values, truncation of negative means, min/max seeded by the first sample.
  task automatic test_directed_extremes();
    send_sample(-32768, 1'b1);
    send_sample(32767, 1'b1);
    send_sample(0, 1'b1);
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b1);
    send_sample(-3, 1'b0);
    send_sample(-2, 1'b1);
    send_sample(3, 1'b0);
    send_sample(2, 1'b1);
    send_sample(5, 1'b0);
    send_sample(7, 1'b0);
    send_sample(9, 1'b1);
    send_sample(-5, 1'b0);
    send_sample(-9, 1'b1);
    send_sample(int'($signed(16'h5555)), 1'b0);
    send_sample(int'($signed(16'haaaa)), 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b1);
    send_sample(-32768, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(-32768, 1'b1);
  endtask

  // One window of n samples, mostly small so that each one is quick.
  task automatic fill_window(input int n);
    int v;
    for (int k = 0; k < n; k++) begin
      if (k >= DEF_MAX_COUNT || k % 512 == 0) begin
        v = int'($signed(16'($urandom)));
      end else begin
        v = $urandom_range(0, 14);
        v -= 7;
      end
      send_sample(v, k == n - 1);
    end
  endtask

  task automatic test_full_window();
    gaps_on = 1'b0;
    fill_window(DEF_MAX_COUNT);
    gaps_on = 1'b1;
  endtask

  // Window runs past capacity; the last mark lands on a dropped sample.
  task automatic test_window_overflow();
    fill_window(DEF_MAX_COUNT + 5);
  endtask

  // Hold the output off long enough that the finished result blocks the next window.
  task automatic test_output_hold();
    hold_req_id <= hold_req_id + 1;
    for (int w = 0; w < 5; w++) begin
      send_sample(random_sample(), 1'b0);
      send_sample(random_sample(), 1'b0);
      send_sample(random_sample(), 1'b1);
    end
  endtask

  task automatic test_random_windows();
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // idle-free stretch over part of the run
      if (sent < RANDOM_ITEMS / 5) begin
        gaps_on = 1'b0;
        ready_gaps_on <= 1'b0;
      end else begin
        gaps_on = 1'b1;
        ready_gaps_on <= 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 10) len = 1;
      else if (r < 80) len = $urandom_range(2, 8);
      else len = $urandom_range(9, 40);
      for (int k = 0; k < len; k++) send_sample(random_sample(), k == len - 1);
      sent += len;
    end
    gaps_on = 1'b1;
    ready_gaps_on <= 1'b1;
  endtask

  initial begin
    clear_window();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_full_window();
    test_window_overflow();
    test_output_hold();
    test_random_windows();

    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d windows from %0d samples, %0d of them dropped past capacity",
             windows_sent, samples_sent, samples_dropped);
    $display("checked %0d results, %0d field mismatches", results_checked, mismatches);
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
